// ----- rtl/core/rmst_pkg.sv -----
package rmst_pkg;

  localparam int unsigned LoWidth  = 10;
  localparam int unsigned HiWidth  = 11;
  localparam int unsigned KeyWidth = 20;
  localparam int unsigned TagWidth = 10;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [LoWidth-1:0]  lo_or_slot;
    logic [HiWidth-1:0]  hi_bound;
    logic                entry_valid;
    logic [KeyWidth-1:0] entry_key;
    logic [TagWidth-1:0] entry_tag;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [KeyWidth-1:0] max_key;
    logic [TagWidth-1:0] max_tag;
    logic [LoWidth-1:0]  max_slot;
  } rsp_t;

endpackage

// ----- rtl/core/rmst_if.sv -----
interface rmst_req_if;
  import rmst_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmst_rsp_if;
  import rmst_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/rmst_node_ram.sv -----
// Node store: one write port, one registered read port.
module rmst_node_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 41
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/range_max_segment_tree.sv -----
// Channel | Dir | Word
// req     | in  | kind, lo_or_slot, hi_bound, entry_valid, entry_key, entry_tag
// rsp     | out | found, max_key, max_tag, max_slot
//
// After reset a clearing pass writes 2*LEAVES nodes, one per cycle, with req ready low.
// One item at a time. A write stores the leaf in its accept cycle (if the slot is in
// range), then walks log2(LEAVES) levels, each with two sibling reads and one parent
// write; rsp is set once the root is written.
// A query steps up level by level in S_QL, reading at most the left and the right
// boundary node per level in S_QLW and S_QRW. The single node memory port serializes these reads.
// rsp holds its word until taken; the next req is taken once rsp is free.
module range_max_segment_tree #(
  parameter int unsigned LEAVES   = 1024,
  parameter int unsigned KEY_BITS = 20
) (
  input logic   clk_i,
  input logic   rst_ni,
  rmst_req_if.sink   req,
  rmst_rsp_if.source rsp
);
  import rmst_pkg::*;

  localparam int unsigned LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned AW = LW + 1;
  localparam int unsigned DW = 1 + KEY_BITS + TagWidth + LW;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [TagWidth-1:0] tag;
    logic [LW-1:0]       slot;
  } node_t;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_WRA  = 9'b000000100,
    S_WRB  = 9'b000001000,
    S_WRC  = 9'b000010000,
    S_QL   = 9'b000100000,
    S_QLW  = 9'b001000000,
    S_QRW  = 9'b010000000,
    S_QEND = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW:0]   x_q, x_d;      // write: node; query: l
  logic [AW:0]   r_q, r_d;
  node_t         a_q, a_d;      // write: left child
  node_t         best_q, best_d;
  logic          rv_q, rv_d;
  rsp_t          rd_q, rd_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wdata, rdata;
  logic [DW-1:0] rraw;

  rmst_node_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rraw)
  );
  assign rdata = node_t'(rraw);

  // better of two nodes; b wins only if valid and a is not, or with a larger key, or equal key at a lower slot
  function automatic node_t pick(node_t a, node_t b);
    logic bb;
    if (!b.valid) bb = 1'b0;
    else if (!a.valid) bb = 1'b1;
    else if (a.key != b.key) bb = b.key > a.key;
    else bb = b.slot < a.slot;
    return bb ? b : a;
  endfunction

  assign req.ready = (state_q == S_IDLE) && !rv_q;
  assign rsp.valid = rv_q;
  assign rsp.data  = rd_q;

  always_comb begin
    logic [HiWidth-1:0] hi;
    logic [AW:0]        l, r;
    state_d = state_q; x_d = x_q; r_d = r_q; a_d = a_q; best_d = best_q;
    rv_d = rv_q; rd_d = rd_q;
    we = 1'b0; waddr = x_q[AW-1:0]; wdata = '0; raddr = x_q[AW-1:0];
    hi = '0; l = '0; r = '0;
    if (rsp.ready) rv_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1;
        x_d = x_q + 1'b1;
        if (x_q == (AW+1)'(2*LEAVES-1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) begin
          rd_d = '0;
          if (req.data.kind == KindWrite) begin
            rd_d.found = 1'b1;
            if (32'(req.data.lo_or_slot) < LEAVES) begin
              we = 1'b1;
              waddr = AW'(LEAVES) + AW'(req.data.lo_or_slot);
              wdata.valid = req.data.entry_valid;
              wdata.key = req.data.entry_valid ? req.data.entry_key[KEY_BITS-1:0] : '0;
              wdata.tag = req.data.entry_valid ? req.data.entry_tag : '0;
              wdata.slot = LW'(req.data.lo_or_slot);
              x_d = (AW+1)'(waddr) >> 1;
              state_d = (x_d == '0) ? S_IDLE : S_WRA;
              if (x_d == '0) rv_d = 1'b1;
            end else rv_d = 1'b1;
          end else begin
            hi = req.data.hi_bound;
            if (32'(hi) >= LEAVES) hi = HiWidth'(LEAVES - 1);
            if (req.data.hi_bound[HiWidth-1] || 32'(req.data.lo_or_slot) >= LEAVES
                || hi < HiWidth'(req.data.lo_or_slot)) begin
              rv_d = 1'b1;
            end else begin
              best_d = '0;
              x_d = (AW+1)'(LEAVES) + (AW+1)'(req.data.lo_or_slot);
              r_d = (AW+1)'(LEAVES) + (AW+1)'(hi) + 1'b1;
              state_d = S_QL;
            end
          end
        end
      end
      // write path: read left, read right, write parent
      S_WRA: begin raddr = {x_q[AW-2:0], 1'b0}; state_d = S_WRB; end
      S_WRB: begin a_d = rdata; raddr = {x_q[AW-2:0], 1'b1}; state_d = S_WRC; end
      S_WRC: begin
        we = 1'b1; wdata = pick(a_q, rdata);
        x_d = x_q >> 1;
        if (x_q == (AW+1)'(1)) begin rv_d = 1'b1; state_d = S_IDLE; end
        else state_d = S_WRA;
      end
      // query step: decide reads for current l, r
      S_QL: begin
        if (x_q >= r_q) state_d = S_QEND;
        else if (x_q[0]) begin raddr = x_q[AW-1:0]; state_d = S_QLW; end
        else if (r_q[0]) begin raddr = AW'(r_q - 1'b1); state_d = S_QRW; end
        else begin x_d = x_q >> 1; r_d = r_q >> 1; end
      end
      S_QLW: begin
        best_d = pick(best_q, rdata);
        l = x_q + 1'b1;
        x_d = l;
        if (r_q[0]) begin raddr = AW'(r_q - 1'b1); state_d = S_QRW; end
        else begin x_d = l >> 1; r_d = r_q >> 1; state_d = S_QL; end
      end
      S_QRW: begin
        best_d = pick(best_q, rdata);
        r = r_q - 1'b1;
        x_d = x_q >> 1; r_d = r >> 1; state_d = S_QL;
      end
      S_QEND: begin
        rv_d = 1'b1;
        rd_d = '0;
        if (best_q.valid) begin
          rd_d.found = 1'b1;
          rd_d.max_key = KeyWidth'(best_q.key);
          rd_d.max_tag = best_q.tag;
          rd_d.max_slot = LoWidth'(best_q.slot);
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      x_q <= '0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      x_q <= x_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; a_q <= a_d; best_q <= best_d; rd_q <= rd_d;
  end
endmodule

// ----- rtl/core/rmst_checker.sv -----
module rmst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_found_i,
  input logic [19:0] rsp_key_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i) else $error("rsp dropped");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i) else $error("req taken while rsp pending");
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_key_i == '0) else $error("key on miss");
endmodule

bind range_max_segment_tree rmst_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_found_i(rsp.data.found),
  .rsp_key_i(rsp.data.max_key)
);
